@@ hw/rtl/fifo_queue_with_search_assert.svh @@
// assertion macros for the fifo queue with search
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define FQS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FQS_ASSERT(lbl, prop, msg)
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/fqs_pkg.sv @@
// shared types and codes for the fifo queue with search
package fqs_pkg;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic    accept;
		logic    push;
		logic    read_head;
		logic    search_next;
		logic    take_data;
		logic    take_pos;
		logic    pop;
		logic    set_status;
		status_t code;
		logic    load_out;
	} fqs_cmd_t;

	typedef struct packed {
		op_t  op;
		logic is_empty;
		logic is_full;
		logic match;
		logic last;
	} fqs_stat_t;
endpackage

@@ hw/rtl/fqs_ctrl.sv @@
// controller state machine of the fifo queue with search
`include "fifo_queue_with_search_assert.svh"
module fqs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  fqs_pkg::fqs_stat_t stat,
	output fqs_pkg::fqs_cmd_t  cmd
);
	import fqs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SRCH,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.code = ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
			end
			S_EXEC: begin
				case (stat.op)
					OP_PUSH: begin
						cmd.set_status = 1'b1;
						if (stat.is_full) begin
							cmd.code = ST_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end
					OP_POP, OP_PEEK, OP_SEARCH: begin
						if (stat.is_empty) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_EMPTY;
						end else begin
							cmd.read_head = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_READ: begin
				cmd.take_data = 1'b1;
				cmd.pop       = (stat.op == OP_POP);
			end
			S_SRCH: begin
				if (stat.match) begin
					cmd.take_pos = 1'b1;
				end else if (stat.last) begin
					cmd.set_status = 1'b1;
					cmd.code       = ST_NOT_FOUND;
				end else begin
					cmd.search_next = 1'b1;
				end
			end
			S_DONE: begin
				cmd.load_out = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.read_head) begin
						state_q <= (stat.op == OP_SEARCH) ? S_SRCH : S_READ;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_SRCH: begin
					if (!cmd.search_next) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FQS_ASSERT(a_load_when_free, !(cmd.load_out && out_valid_q && out_stall), "result overwritten while stalled")
	`FQS_ASSERT_NEXT(a_busy_after_accept, cmd.accept, in_stall, "request accepted but not busy")
	`FQS_ASSERT(a_one_action, $onehot0({cmd.push, cmd.read_head, cmd.take_data, cmd.take_pos, cmd.search_next}), "conflicting datapath commands")
endmodule

@@ hw/rtl/fqs_dpath.sv @@
// ring store, pointers, search counter and result registers
`include "fifo_queue_with_search_assert.svh"
module fqs_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  operation,
	input  logic signed [fqs_pkg::DATA_W-1:0] item_value,
	input  fqs_pkg::fqs_cmd_t           cmd,
	output fqs_pkg::fqs_stat_t          stat,
	output logic signed [fqs_pkg::DATA_W-1:0] result_value,
	output logic [1:0]                  status,
	output logic                        queue_empty
);
	import fqs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] val_q;
	op_t               op_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     slot_q;
	logic [AW-1:0]     k_q;
	logic [DATA_W-1:0] res_q;
	status_t           st_q;
	logic [DATA_W-1:0] out_value_q;
	status_t           out_status_q;
	logic              out_empty_q;

	logic [AW-1:0] slot_nxt;
	logic [AW-1:0] head_nxt;
	logic [AW-1:0] tail_nxt;
	logic [AW-1:0] rd_addr;
	logic          rd_en;

	assign slot_nxt = (slot_q == AW'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign head_nxt = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign rd_addr  = cmd.read_head ? head_q : slot_nxt;
	assign rd_en    = cmd.read_head || cmd.search_next;

	assign stat.op       = op_q;
	assign stat.is_empty = (count_q == '0);
	assign stat.is_full  = (count_q == CW'(DEPTH));
	assign stat.match    = (rd_q == val_q);
	assign stat.last     = ((CW'(k_q) + CW'(1)) == count_q);

	assign result_value = out_value_q;
	assign status       = out_status_q;
	assign queue_empty  = out_empty_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= val_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_t'(operation);
			val_q <= item_value;
		end
		if (cmd.read_head) begin
			slot_q <= head_q;
			k_q    <= '0;
		end else if (cmd.search_next) begin
			slot_q <= slot_nxt;
			k_q    <= k_q + 1'b1;
		end
		if (cmd.take_data) begin
			res_q <= rd_q;
			st_q  <= ST_OK;
		end else if (cmd.take_pos) begin
			res_q <= DATA_W'(k_q) + DATA_W'(1);
			st_q  <= ST_OK;
		end else if (cmd.set_status) begin
			res_q <= '0;
			st_q  <= cmd.code;
		end
		if (cmd.load_out) begin
			out_value_q  <= res_q;
			out_status_q <= st_q;
			out_empty_q  <= (count_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				head_q  <= head_nxt;
				count_q <= count_q - 1'b1;
			end
		end
	end

	`FQS_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count beyond depth")
	`FQS_ASSERT(a_push_room, !(cmd.push && stat.is_full), "push into a full ring")
	`FQS_ASSERT(a_ring_meet, !((count_q == '0 || count_q == CW'(DEPTH)) && head_q != tail_q), "pointers disagree with count")
endmodule

@@ hw/rtl/fifo_queue_with_search.sv @@
// top level of the fifo queue with search
// Bounded first-in first-out queue of signed 32-bit values with a search request.
// Input channel: in_valid, in_stall, operation, item_value (0 push, 1 pop,
// 2 peek, 3 search). Output channel: out_valid, out_stall, result_value,
// status, queue_empty. Exactly one result per request, in request order.
// One request is worked at a time; in_stall is high from acceptance until its
// result has been moved into the output register.
// From acceptance, a push and any refused or empty request pass through S_EXEC
// and S_DONE, a pop or peek through S_EXEC, S_READ and S_DONE, and a search
// through S_EXEC, S_SRCH until a match or the last entry, and S_DONE; a search
// that matches returns the 1-based position of the first match.
// The search walks the ring one entry per cycle
// through the single read port of the store.
// While the receiver stalls, the finished result waits in the output
// register; the next request is still accepted and worked, and its result
// waits inside until the output register is free.
// Reset empties the queue and clears out_valid; stored entries are not cleared.
module fifo_queue_with_search #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  operation,
	input  logic signed [fqs_pkg::DATA_W-1:0] item_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [fqs_pkg::DATA_W-1:0] result_value,
	output logic [1:0]                  status,
	output logic                        queue_empty
);
	import fqs_pkg::*;

	fqs_cmd_t  cmd;
	fqs_stat_t stat;

	fqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fqs_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.item_value   (item_value),
		.cmd          (cmd),
		.stat         (stat),
		.result_value (result_value),
		.status       (status),
		.queue_empty  (queue_empty)
	);
endmodule

@@ test/fifo_queue_with_search_tb.sv @@
// testbench for the fifo queue with search: directed and random requests against a queue predictor
`timescale 1ns / 1ps

module fifo_queue_with_search_tb;
	import fqs_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 1500;

	typedef logic signed [DATA_W-1:0] word_t;

	class queue_scoreboard;
		typedef struct packed {
			word_t   value;
			status_t code;
			logic    empty;
		} result_t;

		word_t   ring [DEPTH];
		int      head;
		int      tail;
		int      count;
		int      errors;
		result_t expected_results [$];

		function new();
			head = 0;
			tail = 0;
			count = 0;
			errors = 0;
		endfunction

		function int backlog();
			return expected_results.size();
		endfunction

		function word_t stored_at(int k);
			return ring[(head + k) % DEPTH];
		endfunction

		// predict the result of one accepted request and update the queue
		function void note_request(op_t op, word_t val);
			result_t r;
			r.value = '0;
			r.code = ST_OK;
			case (op)
			OP_PUSH: begin
				if (count >= DEPTH) begin
					r.code = ST_FULL;
				end else begin
					ring[tail] = val;
					tail = (tail + 1) % DEPTH;
					count++;
				end
			end
			OP_POP, OP_PEEK: begin
				if (count == 0) begin
					r.code = ST_EMPTY;
				end else begin
					r.value = ring[head];
					if (op == OP_POP) begin
						head = (head + 1) % DEPTH;
						count--;
					end
				end
			end
			default: begin
				if (count == 0) begin
					r.code = ST_EMPTY;
				end else begin
					r.code = ST_NOT_FOUND;
					for (int k = 0; k < count; k++) begin
						if (ring[(head + k) % DEPTH] == val) begin
							r.code = ST_OK;
							r.value = k + 1;
							break;
						end
					end
				end
			end
			endcase
			r.empty = (count == 0);
			expected_results.push_back(r);
		endfunction

		function void check_result(word_t val, logic [1:0] st, logic empty);
			result_t r;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result value %0d status %0d empty %0b",
					$time, val, st, empty);
				errors++;
				return;
			end
			r = expected_results.pop_front();
			if (val !== r.value) begin
				$display("%0t: result_value expected %0d actual %0d", $time, r.value, val);
				errors++;
			end
			if (st !== r.code) begin
				$display("%0t: status expected %s actual %0d", $time, r.code.name(), st);
				errors++;
			end
			if (empty !== r.empty) begin
				$display("%0t: queue_empty expected %0b actual %0b", $time, r.empty, empty);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] operation = OP_PUSH;
	word_t      item_value = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	word_t      result_value;
	logic [1:0] status;
	logic       queue_empty;

	int stall_mode = 0;
	int stall_left = 0;

	queue_scoreboard sb;

	fifo_queue_with_search #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.status(status),
		.queue_empty(queue_empty)
	);

	always #5 clk = ~clk;

	// receiver stall pattern: one of four randomly chosen modes, redrawn when its counter runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
		0: out_stall <= 1'b0;
		1: out_stall <= ($urandom_range(0, 1) == 1);
		2: out_stall <= ($urandom_range(0, 9) != 0);
		default: out_stall <= ((stall_left % 7) < 3);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_value, status, queue_empty);
	end

	task automatic send_request(input op_t op, input word_t val);
		in_valid <= 1'b1;
		operation <= op;
		item_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(op, val);
	endtask

	function automatic word_t random_value();
		case ($urandom_range(0, 5))
		0: begin
			case ($urandom_range(0, 3))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			default: return '1;
			endcase
		end
		1, 2: return $signed($urandom_range(0, 7)) - 4;
		default: return $urandom();
		endcase
	endfunction

	task automatic random_request(input int mix);
		int    p_push;
		int    p_pop;
		int    p_peek;
		int    r;
		word_t val;
		op_t   op;
		case (mix)
		0: begin p_push = 55; p_pop = 10; p_peek = 10; end
		1: begin p_push = 10; p_pop = 50; p_peek = 15; end
		2: begin p_push = 35; p_pop = 30; p_peek = 10; end
		default: begin p_push = 25; p_pop = 20; p_peek = 10; end
		endcase
		r = $urandom_range(0, 99);
		if (r < p_push)
			op = OP_PUSH;
		else if (r < p_push + p_pop)
			op = OP_POP;
		else if (r < p_push + p_pop + p_peek)
			op = OP_PEEK;
		else
			op = OP_SEARCH;
		// searches mostly look for something that is stored
		if (op == OP_SEARCH && sb.count > 0 && $urandom_range(0, 99) < 65)
			val = sb.stored_at($urandom_range(0, sb.count - 1));
		else
			val = random_value();
		send_request(op, val);
	endtask

	initial begin
		int sent;
		int burst;
		int mix;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, extremes, fill to full and push once more, search second, last and absent values
		send_request(OP_POP, 32'sh0000_0011);
		send_request(OP_PEEK, '1);
		send_request(OP_SEARCH, '0);
		send_request(OP_PUSH, 32'sh8000_0000);
		send_request(OP_PUSH, 32'sh7fff_ffff);
		send_request(OP_PUSH, '1);
		send_request(OP_PUSH, '0);
		for (int k = 0; k < 11; k++)
			send_request(OP_PUSH, k * 1000 - 7);
		send_request(OP_PUSH, 32'sh1234_5678);
		send_request(OP_PUSH, 32'sh7fff_ffff);
		send_request(OP_SEARCH, 32'sh7fff_ffff);
		send_request(OP_SEARCH, 32'sh1234_5678);
		send_request(OP_SEARCH, 32'sh5a5a_a5a5);
		send_request(OP_PEEK, '0);
		send_request(OP_POP, '0);
		send_request(OP_POP, '0);

		// let everything drain before random traffic
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.backlog() != 0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			mix = $urandom_range(0, 3);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				random_request(mix);
				sent++;
			end
			if ($urandom_range(0, 19) == 0) begin
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (sb.backlog() != 0);
			end else if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (sb.backlog() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		if (sb.errors == 0 && sb.backlog() == 0) begin
			$display("[fifo_queue_with_search] OK");
		end else begin
			$display("[fifo_queue_with_search] ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[fifo_queue_with_search] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/fqs_pkg.sv
hw/rtl/fqs_ctrl.sv
hw/rtl/fqs_dpath.sv
hw/rtl/fifo_queue_with_search.sv
test/fifo_queue_with_search_tb.sv
